@@ rtl/lks_pkg.sv @@
// Link keepalive supervisor package: link states, command, role, op and error codes,
// register indexes, reset values of the configuration registers, item structs
// and the state code mapping. No dependencies.
package lks_pkg;

  // Link state, one-hot inside the block.
  typedef enum logic [6:0] {
    ST_IDLE         = 7'b0000001,
    ST_FINDING      = 7'b0000010,
    ST_CONN_MASTER  = 7'b0000100,
    ST_CONN_SLAVE   = 7'b0001000,
    ST_DISCONNECTED = 7'b0010000,
    ST_RECONNECTING = 7'b0100000,
    ST_ERROR        = 7'b1000000
  } link_state_e;

  // Link state as reported on the result channel.
  localparam logic [2:0] CODE_IDLE         = 3'd0;
  localparam logic [2:0] CODE_FINDING      = 3'd1;
  localparam logic [2:0] CODE_CONN_MASTER  = 3'd2;
  localparam logic [2:0] CODE_CONN_SLAVE   = 3'd3;
  localparam logic [2:0] CODE_DISCONNECTED = 3'd4;
  localparam logic [2:0] CODE_RECONNECTING = 3'd5;
  localparam logic [2:0] CODE_ERROR        = 3'd6;

  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_ERROR  = 2'd2;

  localparam logic [2:0] CMD_PING       = 3'd0;
  localparam logic [2:0] CMD_PONG       = 3'd1;
  localparam logic [2:0] CMD_REQ_STATS  = 3'd2;
  localparam logic [2:0] CMD_SEND_STATS = 3'd3;

  localparam logic [1:0] ROLE_MASTER = 2'd0;
  localparam logic [1:0] ROLE_SLAVE  = 2'd1;

  localparam logic [1:0] ERR_TIMEOUT    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN    = 2'd1;
  localparam logic [1:0] ERR_UNEXP_ROLE = 2'd2;

  localparam logic [1:0] PERR_NONE      = 2'd0;
  localparam logic [1:0] PERR_SAME_ROLE = 2'd1;
  localparam logic [1:0] PERR_UNKNOWN   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEVICE_ROLE    = 3'd0;
  localparam logic [2:0] REG_PING_INTERVAL  = 3'd1;
  localparam logic [2:0] REG_PONG_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_STATS_INTERVAL = 3'd3;
  localparam logic [2:0] REG_SLAVE_TIMEOUT  = 3'd4;

  localparam logic [1:0]  RST_DEVICE_ROLE    = 2'd0;
  localparam logic [15:0] RST_PING_INTERVAL  = 16'd100;
  localparam logic [15:0] RST_PONG_TIMEOUT   = 16'd100;
  localparam logic [15:0] RST_STATS_INTERVAL = 16'd20;
  localparam logic [15:0] RST_SLAVE_TIMEOUT  = 16'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [1:0]  src_role;
    logic [2:0]  command;
    logic        stats_length_ok;
    logic [1:0]  error_kind;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [1:0] send_command;
    logic [2:0] link_state_out;
    logic [1:0] packet_error;
    logic       stats_accepted;
  } res_item_t;

  function automatic logic [2:0] state_code(link_state_e st);
    logic [2:0] code;
    case (st)
      ST_IDLE:         code = CODE_IDLE;
      ST_FINDING:      code = CODE_FINDING;
      ST_CONN_MASTER:  code = CODE_CONN_MASTER;
      ST_CONN_SLAVE:   code = CODE_CONN_SLAVE;
      ST_DISCONNECTED: code = CODE_DISCONNECTED;
      ST_RECONNECTING: code = CODE_RECONNECTING;
      ST_ERROR:        code = CODE_ERROR;
      default:         code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/lks_if.sv @@
// Valid/ready channel interfaces of the link keepalive supervisor:
// one for incoming items, one for result items. No dependencies.
interface lks_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [1:0]  src_role;
  logic [2:0]  command;
  logic        stats_length_ok;
  logic [1:0]  error_kind;

  modport source (output valid, op, now_ms, src_role, command, stats_length_ok,
                  error_kind, input ready);
  modport sink   (input valid, op, now_ms, src_role, command, stats_length_ok,
                  error_kind, output ready);
endinterface

interface lks_res_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [1:0] send_command;
  logic [2:0] link_state_out;
  logic [1:0] packet_error;
  logic       stats_accepted;

  modport source (output valid, send_valid, send_command, link_state_out, packet_error,
                  stats_accepted, input ready);
  modport sink   (input valid, send_valid, send_command, link_state_out, packet_error,
                  stats_accepted, output ready);
endinterface

@@ rtl/link_keepalive_supervisor_unit.sv @@
// Top level of the link keepalive supervisor.
// Depends on lks_pkg and the channel interfaces in lks_if.sv.

// Master/slave keepalive supervisor. Each input item (poll tick, received
// packet or link error, all stamped with a 32-bit millisecond time) yields
// exactly one result item: whether a packet goes out and which command, the
// link state after the item, a packet error code and a stats-accepted flag.
// Elapsed times are taken with wrapping 32-bit subtraction against the
// stored stamps. Throughput is one item per cycle while res_o.ready keeps up;
// each item passes through the input register, then the result register,
// with the decision logic and the state update between them. The result
// register is backed by the input register, so a new item is taken while a
// finished result waits; in_i.ready falls only when both hold an item and
// res_o.ready is low. Configuration writes take effect at once and do not
// reset the link; write them only while the block is idle.
module link_keepalive_supervisor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lks_in_if.sink      in_i,
  lks_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Configuration registers
  logic [1:0]  role_q;
  logic [15:0] ping_ivl_q, pong_tmo_q, stats_ivl_q, slave_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= lks_pkg::RST_DEVICE_ROLE;
      ping_ivl_q  <= lks_pkg::RST_PING_INTERVAL;
      pong_tmo_q  <= lks_pkg::RST_PONG_TIMEOUT;
      stats_ivl_q <= lks_pkg::RST_STATS_INTERVAL;
      slave_tmo_q <= lks_pkg::RST_SLAVE_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lks_pkg::REG_DEVICE_ROLE:    role_q      <= cfg_wdata_i[1:0];
        lks_pkg::REG_PING_INTERVAL:  ping_ivl_q  <= cfg_wdata_i;
        lks_pkg::REG_PONG_TIMEOUT:   pong_tmo_q  <= cfg_wdata_i;
        lks_pkg::REG_STATS_INTERVAL: stats_ivl_q <= cfg_wdata_i;
        lks_pkg::REG_SLAVE_TIMEOUT:  slave_tmo_q <= cfg_wdata_i;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // Handshake: item in the input register moves on when the result register
  // is empty or its item is being taken.
  logic              in_valid_q, out_valid_q, advance;
  lks_pkg::in_item_t in_q;
  lks_pkg::res_item_t res_q, res_d;

  assign advance    = !out_valid_q || res_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.op              <= in_i.op;
      in_q.now_ms          <= in_i.now_ms;
      in_q.src_role        <= in_i.src_role;
      in_q.command         <= in_i.command;
      in_q.stats_length_ok <= in_i.stats_length_ok;
      in_q.error_kind      <= in_i.error_kind;
    end
  end

  // Link state and timestamps
  lks_pkg::link_state_e st_q, st_d;
  logic [31:0] ping_sent_q, ping_sent_d;     // master: last ping sent
  logic [31:0] stats_req_q, stats_req_d;     // master: last stats request
  logic [31:0] pong_seen_q, pong_seen_d;     // master: last pong received
  logic [31:0] mst_ping_q, mst_ping_d;       // slave: last ping from master

  // Wrapping elapsed times
  logic [31:0] since_ping, since_stats, since_pong, since_mst;
  assign since_ping  = in_q.now_ms - ping_sent_q;
  assign since_stats = in_q.now_ms - stats_req_q;
  assign since_pong  = in_q.now_ms - pong_seen_q;
  assign since_mst   = in_q.now_ms - mst_ping_q;

  logic is_master, is_slave, master_link, slave_link;
  assign is_master   = (role_q == lks_pkg::ROLE_MASTER);
  assign is_slave    = (role_q == lks_pkg::ROLE_SLAVE);
  assign master_link = is_master && (in_q.src_role == lks_pkg::ROLE_SLAVE);
  assign slave_link  = is_slave && (in_q.src_role == lks_pkg::ROLE_MASTER);

  logic       tx_v;
  logic [1:0] tx_cmd;
  logic [1:0] perr;
  logic       accepted;

  always_comb begin
    st_d        = st_q;
    ping_sent_d = ping_sent_q;
    stats_req_d = stats_req_q;
    pong_seen_d = pong_seen_q;
    mst_ping_d  = mst_ping_q;
    tx_v        = 1'b0;
    tx_cmd      = 2'd0;
    perr        = lks_pkg::PERR_NONE;
    accepted    = 1'b0;

    case (in_q.op)
      lks_pkg::OP_POLL: begin
        if (is_master) begin
          case (st_q)
            lks_pkg::ST_IDLE, lks_pkg::ST_RECONNECTING: begin
              // Back-date the ping stamp so the next tick pings at once.
              st_d        = lks_pkg::ST_FINDING;
              ping_sent_d = in_q.now_ms - {16'd0, ping_ivl_q};
            end
            lks_pkg::ST_FINDING: begin
              if (since_ping >= {16'd0, ping_ivl_q}) begin
                tx_v        = 1'b1;
                tx_cmd      = lks_pkg::CMD_PING[1:0];
                ping_sent_d = in_q.now_ms;
              end
            end
            lks_pkg::ST_CONN_MASTER: begin
              if (since_pong > {16'd0, pong_tmo_q}) begin
                st_d = lks_pkg::ST_RECONNECTING;
              end else if (since_stats >= {16'd0, stats_ivl_q}) begin
                tx_v        = 1'b1;
                tx_cmd      = lks_pkg::CMD_REQ_STATS[1:0];
                stats_req_d = in_q.now_ms;
              end
            end
            default: st_d = lks_pkg::ST_RECONNECTING;
          endcase
        end else if (is_slave) begin
          case (st_q)
            lks_pkg::ST_IDLE, lks_pkg::ST_RECONNECTING: begin
              st_d       = lks_pkg::ST_DISCONNECTED;
              mst_ping_d = 32'd0;
            end
            lks_pkg::ST_CONN_SLAVE: begin
              if (since_mst > {16'd0, slave_tmo_q}) begin
                st_d = lks_pkg::ST_RECONNECTING;
              end
            end
            lks_pkg::ST_DISCONNECTED: ;
            default: st_d = lks_pkg::ST_RECONNECTING;
          endcase
        end
      end
      lks_pkg::OP_PACKET: begin
        if (in_q.src_role == role_q) begin
          st_d = lks_pkg::ST_ERROR;
          perr = lks_pkg::PERR_SAME_ROLE;
        end else begin
          case (in_q.command)
            lks_pkg::CMD_PING: begin
              if (slave_link) begin
                mst_ping_d = in_q.now_ms;
                tx_v       = 1'b1;
                tx_cmd     = lks_pkg::CMD_PONG[1:0];
                st_d       = lks_pkg::ST_CONN_SLAVE;
              end
            end
            lks_pkg::CMD_PONG: begin
              if (master_link) begin
                pong_seen_d = in_q.now_ms;
                if (st_q != lks_pkg::ST_CONN_MASTER) begin
                  // Fresh connection: first stats request goes out next tick.
                  st_d        = lks_pkg::ST_CONN_MASTER;
                  stats_req_d = in_q.now_ms - {16'd0, stats_ivl_q};
                end
              end
            end
            lks_pkg::CMD_REQ_STATS: begin
              if (slave_link) begin
                tx_v   = 1'b1;
                tx_cmd = lks_pkg::CMD_SEND_STATS[1:0];
              end
            end
            lks_pkg::CMD_SEND_STATS: accepted = master_link && in_q.stats_length_ok;
            default: perr = lks_pkg::PERR_UNKNOWN;
          endcase
        end
      end
      lks_pkg::OP_ERROR: begin
        if (in_q.error_kind == lks_pkg::ERR_TIMEOUT ||
            in_q.error_kind == lks_pkg::ERR_OVERRUN) begin
          if (st_q == lks_pkg::ST_CONN_MASTER || st_q == lks_pkg::ST_CONN_SLAVE) begin
            st_d = lks_pkg::ST_RECONNECTING;
          end
        end else if (in_q.error_kind == lks_pkg::ERR_UNEXP_ROLE) begin
          st_d = lks_pkg::ST_ERROR;
        end
      end
      default: ;  // undefined op: report current state only
    endcase

    res_d.send_valid     = tx_v;
    res_d.send_command   = tx_cmd;
    res_d.link_state_out = lks_pkg::state_code(st_d);
    res_d.packet_error   = perr;
    res_d.stats_accepted = accepted;
  end

  // State commits when the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lks_pkg::ST_IDLE;
      ping_sent_q <= 32'd0;
      stats_req_q <= 32'd0;
      pong_seen_q <= 32'd0;
      mst_ping_q  <= 32'd0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        st_q        <= st_d;
        ping_sent_q <= ping_sent_d;
        stats_req_q <= stats_req_d;
        pong_seen_q <= pong_seen_d;
        mst_ping_q  <= mst_ping_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.send_valid     = res_q.send_valid;
  assign res_o.send_command   = res_q.send_command;
  assign res_o.link_state_out = res_q.link_state_out;
  assign res_o.packet_error   = res_q.packet_error;
  assign res_o.stats_accepted = res_q.stats_accepted;

endmodule

@@ rtl/lks_chk.sv @@
// Port-level checker for the link keepalive supervisor and its bind.
// Depends on lks_pkg and link_keepalive_supervisor_unit.
module lks_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic       send_valid,
  input logic [1:0] send_command,
  input logic [2:0] link_state_out,
  input logic [1:0] packet_error,
  input logic       stats_accepted
);

  // No command bits without a transmit.
  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !send_valid) |-> (send_command == 2'd0))
    else $error("send_command set without send_valid");

  // A same-role packet error always lands the link in error, with nothing sent and no stats accepted.
  a_same_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && packet_error == lks_pkg::PERR_SAME_ROLE)
      |-> (link_state_out == lks_pkg::CODE_ERROR && !send_valid && !stats_accepted))
    else $error("same-role packet did not force error state");

  // Accepted stats come only from a master-side packet: nothing sent, no error.
  a_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && stats_accepted)
      |-> (!send_valid && packet_error == lks_pkg::PERR_NONE))
    else $error("stats accepted alongside a transmit or error");

  // A pong goes out only with the link reported as connected slave.
  a_pong_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && send_valid && send_command == lks_pkg::CMD_PONG[1:0])
      |-> (link_state_out == lks_pkg::CODE_CONN_SLAVE))
    else $error("pong sent outside connected slave state");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(link_state_out)
      && $stable(send_valid) && $stable(send_command)))
    else $error("stalled result changed");

endmodule

bind link_keepalive_supervisor_unit lks_chk u_lks_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .send_valid     (res_o.send_valid),
  .send_command   (res_o.send_command),
  .link_state_out (res_o.link_state_out),
  .packet_error   (res_o.packet_error),
  .stats_accepted (res_o.stats_accepted)
);

@@ tb/link_keepalive_supervisor_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench of link_keepalive_supervisor_unit: directed table then randomized phases, every result
// checked against an in-bench model of the keepalive supervisor or, for typed rows, against the table.
// Depends on lks_pkg, lks_in_if / lks_res_if and the unit itself.
module link_keepalive_supervisor_unit_tb;
  import lks_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 500000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 152;
  localparam int unsigned MAX_IDLE      = 8;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  // Two-stage pipeline; the tail wait catches stray results.
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Codes the package leaves unnamed, and stamp and interval limits.
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [1:0]  ERR_OTHER    = 2'd3;
  localparam logic [1:0]  ROLE_SPARE_A = 2'd2;
  localparam logic [1:0]  ROLE_SPARE_B = 2'd3;
  localparam logic [2:0]  CMD_UNDEF_LO = 3'd4;
  localparam logic [2:0]  CMD_UNDEF_HI = 3'd7;
  localparam logic [31:0] STAMP_MAX    = 32'hFFFF_FFFF;
  localparam logic [15:0] IVL_MIN      = 16'd1;
  localparam logic [15:0] IVL_MAX      = 16'hFFFF;

  // Transmit command codes as they appear on the 2-bit result field.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] TX_PING   = 2'(CMD_PING);
  localparam logic [1:0] TX_PONG   = 2'(CMD_PONG);
  localparam logic [1:0] TX_REQ    = 2'(CMD_REQ_STATS);
  localparam logic [1:0] TX_STATS  = 2'(CMD_SEND_STATS);

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: either an item or a register write.
  // Rows marked typed carry their expected result in the row itself.
  typedef struct {
    row_kind_e  kind;
    in_item_t   item;
    logic [2:0] reg_idx;
    logic [15:0] reg_val;
    bit         typed;
    res_item_t  result;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  lks_in_if  in_if ();
  lks_res_if res_if ();

  link_keepalive_supervisor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the supervisor: own copy of registers and link bookkeeping.
  // ---------------------------------------------------------------------------
  logic [1:0]  cfg_role;
  logic [15:0] cfg_ping_ivl;
  logic [15:0] cfg_pong_tmo;
  logic [15:0] cfg_stats_ivl;
  logic [15:0] cfg_slave_tmo;

  logic [2:0]  link_code;
  logic [31:0] ping_sent_ms;
  logic [31:0] stats_req_ms;
  logic [31:0] pong_seen_ms;
  logic [31:0] master_ping_ms;

  res_item_t   link_reports_due[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          tx_burst = 1'b0;
  logic [31:0] stamp_ms;

  // Applies one item to the model state and returns the result it causes.
  // All elapsed-time math is mod 2^32 on the 32-bit stamps.
  function automatic res_item_t supervise_item(in_item_t it);
    res_item_t   r;
    logic        master_link;
    logic        slave_link;
    logic [31:0] now;
    now = it.now_ms;
    r = '0;
    master_link = (cfg_role == ROLE_MASTER) && (it.src_role == ROLE_SLAVE);
    slave_link  = (cfg_role == ROLE_SLAVE) && (it.src_role == ROLE_MASTER);
    case (it.op)
      OP_POLL: begin
        if (cfg_role == ROLE_MASTER) begin
          case (link_code)
            CODE_IDLE, CODE_RECONNECTING: begin
              // Back-date the last ping so the next tick pings at once.
              link_code = CODE_FINDING;
              ping_sent_ms = now - 32'(cfg_ping_ivl);
            end
            CODE_FINDING: begin
              if (now - ping_sent_ms >= 32'(cfg_ping_ivl)) begin
                r.send_valid = 1'b1;
                r.send_command = TX_PING;
                ping_sent_ms = now;
              end
            end
            CODE_CONN_MASTER: begin
              if (now - pong_seen_ms > 32'(cfg_pong_tmo)) begin
                link_code = CODE_RECONNECTING;
              end else if (now - stats_req_ms >= 32'(cfg_stats_ivl)) begin
                r.send_valid = 1'b1;
                r.send_command = TX_REQ;
                stats_req_ms = now;
              end
            end
            default: link_code = CODE_RECONNECTING;
          endcase
        end else if (cfg_role == ROLE_SLAVE) begin
          case (link_code)
            CODE_IDLE, CODE_RECONNECTING: begin
              link_code = CODE_DISCONNECTED;
              master_ping_ms = '0;
            end
            CODE_CONN_SLAVE: begin
              if (now - master_ping_ms > 32'(cfg_slave_tmo)) link_code = CODE_RECONNECTING;
            end
            CODE_DISCONNECTED: ;
            default: link_code = CODE_RECONNECTING;
          endcase
        end
      end
      OP_PACKET: begin
        if (it.src_role == cfg_role) begin
          // Same-role sender wins over every command check, even when inactive.
          link_code = CODE_ERROR;
          r.packet_error = PERR_SAME_ROLE;
        end else begin
          case (it.command)
            CMD_PING: begin
              if (slave_link) begin
                master_ping_ms = now;
                r.send_valid = 1'b1;
                r.send_command = TX_PONG;
                link_code = CODE_CONN_SLAVE;
              end
            end
            CMD_PONG: begin
              if (master_link) begin
                pong_seen_ms = now;
                if (link_code != CODE_CONN_MASTER) begin
                  link_code = CODE_CONN_MASTER;
                  stats_req_ms = now - 32'(cfg_stats_ivl);
                end
              end
            end
            CMD_REQ_STATS: begin
              if (slave_link) begin
                r.send_valid = 1'b1;
                r.send_command = TX_STATS;
              end
            end
            CMD_SEND_STATS: r.stats_accepted = master_link && it.stats_length_ok;
            default: r.packet_error = PERR_UNKNOWN;
          endcase
        end
      end
      OP_ERROR: begin
        case (it.error_kind)
          ERR_TIMEOUT, ERR_OVERRUN: begin
            if (link_code == CODE_CONN_MASTER || link_code == CODE_CONN_SLAVE)
              link_code = CODE_RECONNECTING;
          end
          ERR_UNEXP_ROLE: link_code = CODE_ERROR;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.link_state_out = link_code;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, logic [31:0] now, logic [1:0] sender,
                                       logic [2:0] cmd, logic len_ok, logic [1:0] ekind);
    in_item_t it;
    it.op = op;
    it.now_ms = now;
    it.src_role = sender;
    it.command = cmd;
    it.stats_length_ok = len_ok;
    it.error_kind = ekind;
    return it;
  endfunction

  function automatic script_row_t step_row(in_item_t it);
    script_row_t row;
    row = '{ROW_ITEM, it, REG_DEVICE_ROLE, 16'd0, 1'b0, res_item_t'('0)};
    return row;
  endfunction

  function automatic script_row_t check_row(in_item_t it, res_item_t res);
    script_row_t row;
    row = '{ROW_ITEM, it, REG_DEVICE_ROLE, 16'd0, 1'b1, res};
    return row;
  endfunction

  function automatic script_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    script_row_t row;
    row = '{ROW_CFG, in_item_t'('0), idx, val, 1'b0, res_item_t'('0)};
    return row;
  endfunction

  // Mix of tiny, moderate, large and full-scale interval values.
  function automatic logic [15:0] draw_interval();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(1, 8));
      1:       return 16'($urandom_range(9, 300));
      2:       return 16'($urandom_range(301, 65535));
      default: return IVL_MAX;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and waits for the handshake. Valid stays
  // high across back-to-back items so it is never dropped and raised in one step.
  task automatic send_item(in_item_t it, bit typed, res_item_t typed_res);
    int unsigned gap;
    res_item_t   exp;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.op              <= it.op;
    in_if.now_ms          <= it.now_ms;
    in_if.src_role        <= it.src_role;
    in_if.command         <= it.command;
    in_if.stats_length_ok <= it.stats_length_ok;
    in_if.error_kind      <= it.error_kind;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    exp = supervise_item(it);
    if (typed) exp = typed_res;
    link_reports_due.push_back(exp);
  endtask

  // Stop offering items and let every outstanding result come back.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (link_reports_due.size() != 0) @(posedge clk_i);
  endtask

  // Write enable stays high across consecutive writes; caller drops it.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEVICE_ROLE:    cfg_role = val[1:0];
      REG_PING_INTERVAL:  cfg_ping_ivl = val;
      REG_PONG_TIMEOUT:   cfg_pong_tmo = val;
      REG_STATS_INTERVAL: cfg_stats_ivl = val;
      REG_SLAVE_TIMEOUT:  cfg_slave_tmo = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    script_row_t    directed[$];
    in_item_t       it;
    logic [15:0]    role_val;
    logic [15:0]    ping_val, pong_val, stats_val, slave_val;
    logic [1:0]     counterpart;
    int unsigned    ivl;
    int unsigned    pick;
    int unsigned    k;

    in_if.valid           = 1'b0;
    in_if.op              = OP_POLL;
    in_if.now_ms          = '0;
    in_if.src_role        = ROLE_MASTER;
    in_if.command         = CMD_PING;
    in_if.stats_length_ok = 1'b0;
    in_if.error_kind      = ERR_TIMEOUT;
    cfg_we                = 1'b0;
    cfg_idx               = REG_DEVICE_ROLE;
    cfg_wdata             = '0;

    // Model starts from the documented reset values.
    cfg_role       = RST_DEVICE_ROLE;
    cfg_ping_ivl   = RST_PING_INTERVAL;
    cfg_pong_tmo   = RST_PONG_TIMEOUT;
    cfg_stats_ivl  = RST_STATS_INTERVAL;
    cfg_slave_tmo  = RST_SLAVE_TIMEOUT;
    link_code      = CODE_IDLE;
    ping_sent_ms   = '0;
    stats_req_ms   = '0;
    pong_seen_ms   = '0;
    master_ping_ms = '0;

    // Master at reset defaults: search, connect, stats, errors.
    directed.push_back(check_row(mk_item(OP_POLL, 32'd0, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b0, SEND_NONE, CODE_FINDING, PERR_NONE, 1'b0}));
    directed.push_back(check_row(mk_item(OP_POLL, 32'd0, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b1, TX_PING, CODE_FINDING, PERR_NONE, 1'b0}));
    directed.push_back(step_row(mk_item(OP_POLL, 32'd99, ROLE_SLAVE, CMD_PONG, 1'b1,
      ERR_OVERRUN)));
    // Pong at the top stamp; later items wrap through zero.
    directed.push_back(check_row(mk_item(OP_PACKET, STAMP_MAX, ROLE_SLAVE, CMD_PONG, 1'b1,
      ERR_OTHER), res_item_t'{1'b0, SEND_NONE, CODE_CONN_MASTER, PERR_NONE, 1'b0}));
    directed.push_back(step_row(mk_item(OP_POLL, 32'd19, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd20, ROLE_SLAVE, CMD_SEND_STATS, 1'b1,
      ERR_TIMEOUT), res_item_t'{1'b0, SEND_NONE, CODE_CONN_MASTER, PERR_NONE, 1'b1}));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd21, ROLE_SLAVE, CMD_SEND_STATS, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd22, ROLE_SLAVE, CMD_UNDEF_HI, 1'b1,
      ERR_OTHER), res_item_t'{1'b0, SEND_NONE, CODE_CONN_MASTER, PERR_UNKNOWN, 1'b0}));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd23, ROLE_SPARE_B, CMD_UNDEF_LO, 1'b0,
      ERR_TIMEOUT)));
    // Pong goes stale: one past the timeout.
    directed.push_back(step_row(mk_item(OP_POLL, 32'd100, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd130, ROLE_SLAVE, CMD_PONG, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_ERROR, 32'd131, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_OVERRUN)));
    directed.push_back(step_row(mk_item(OP_ERROR, 32'd132, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd133, ROLE_SPARE_A, CMD_PING, 1'b1,
      ERR_TIMEOUT)));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd134, ROLE_MASTER, CMD_REQ_STATS, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b0, SEND_NONE, CODE_ERROR, PERR_SAME_ROLE, 1'b0}));
    directed.push_back(step_row(mk_item(OP_ERROR, 32'd135, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_OTHER)));
    directed.push_back(step_row(mk_item(OP_UNUSED, 32'd136, ROLE_SLAVE, CMD_PONG, 1'b1,
      ERR_UNEXP_ROLE)));
    directed.push_back(step_row(mk_item(OP_POLL, 32'd137, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));

    // Slave: answer pings and stats requests, time out, error on unexpected role.
    directed.push_back(cfg_row(REG_DEVICE_ROLE, 16'(ROLE_SLAVE)));
    directed.push_back(check_row(mk_item(OP_POLL, 32'd200, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b0, SEND_NONE, CODE_DISCONNECTED, PERR_NONE, 1'b0}));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd1000, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b1, TX_PONG, CODE_CONN_SLAVE, PERR_NONE, 1'b0}));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd1001, ROLE_MASTER, CMD_REQ_STATS, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b1, TX_STATS, CODE_CONN_SLAVE, PERR_NONE, 1'b0}));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd1002, ROLE_MASTER, CMD_PONG, 1'b1,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_ERROR, 32'd1004, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_PACKET, 32'd3000, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(step_row(mk_item(OP_POLL, 32'd4001, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));
    directed.push_back(check_row(mk_item(OP_ERROR, 32'd4002, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_UNEXP_ROLE), res_item_t'{1'b0, SEND_NONE, CODE_ERROR, PERR_NONE, 1'b0}));

    // Inactive role: a packet claiming the same role still has an effect, a poll none.
    directed.push_back(cfg_row(REG_DEVICE_ROLE, 16'(ROLE_SPARE_B)));
    directed.push_back(check_row(mk_item(OP_PACKET, 32'd4003, ROLE_SPARE_B, CMD_PING, 1'b0,
      ERR_TIMEOUT), res_item_t'{1'b0, SEND_NONE, CODE_ERROR, PERR_SAME_ROLE, 1'b0}));
    directed.push_back(step_row(mk_item(OP_POLL, 32'd4004, ROLE_MASTER, CMD_PING, 1'b0,
      ERR_TIMEOUT)));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
        @(negedge clk_i);
        cfg_we <= 1'b0;
      end else begin
        send_item(directed[i].item, directed[i].typed, directed[i].result);
      end
    end

    // Random phases. First all intervals at the minimum, then all at the
    // maximum, then mixed. Roles alternate, two phases run inactive.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        ping_val = IVL_MIN; pong_val = IVL_MIN; stats_val = IVL_MIN; slave_val = IVL_MIN;
      end else if (p == 1) begin
        ping_val = IVL_MAX; pong_val = IVL_MAX; stats_val = IVL_MAX; slave_val = IVL_MAX;
      end else begin
        ping_val = draw_interval();
        pong_val = draw_interval();
        stats_val = draw_interval();
        slave_val = draw_interval();
      end
      if (p == 4)          role_val = 16'(ROLE_SPARE_A);
      else if (p == 9)     role_val = 16'(ROLE_SPARE_B);
      else if (p % 2 == 1) role_val = 16'(ROLE_SLAVE);
      else                 role_val = 16'(ROLE_MASTER);
      write_reg(REG_DEVICE_ROLE, role_val);
      write_reg(REG_PING_INTERVAL, ping_val);
      write_reg(REG_PONG_TIMEOUT, pong_val);
      write_reg(REG_STATS_INTERVAL, stats_val);
      write_reg(REG_SLAVE_TIMEOUT, slave_val);
      @(negedge clk_i);
      cfg_we <= 1'b0;

      stamp_ms = $urandom();
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Step time by up to one and a half of some interval so that
        // timeouts and periods land on both sides; rarely jump anywhere.
        case ($urandom_range(0, 3))
          0:       ivl = cfg_ping_ivl;
          1:       ivl = cfg_pong_tmo;
          2:       ivl = cfg_stats_ivl;
          default: ivl = cfg_slave_tmo;
        endcase
        if ($urandom_range(0, 99) < 3) stamp_ms = $urandom();
        else stamp_ms = stamp_ms + $urandom_range(0, ivl + ivl / 2 + 1);

        if (cfg_role == ROLE_MASTER)     counterpart = ROLE_SLAVE;
        else if (cfg_role == ROLE_SLAVE) counterpart = ROLE_MASTER;
        else                             counterpart = 2'($urandom_range(0, 1));

        it.now_ms = stamp_ms;
        it.stats_length_ok = 1'($urandom_range(0, 1));

        pick = $urandom_range(0, 99);
        if (pick < 45)      it.op = OP_POLL;
        else if (pick < 85) it.op = OP_PACKET;
        else if (pick < 97) it.op = OP_ERROR;
        else                it.op = OP_UNUSED;

        // Mostly the peer role, some same-role and arbitrary senders.
        pick = $urandom_range(0, 99);
        if (pick < 80)      it.src_role = counterpart;
        else if (pick < 88) it.src_role = cfg_role;
        else                it.src_role = 2'($urandom_range(0, 3));

        // Commands the current role expects dominate; undefined ones now and then.
        pick = $urandom_range(0, 99);
        if (pick < 8)
          it.command = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        else if (pick < 50)
          it.command = (cfg_role == ROLE_MASTER) ? CMD_PONG : CMD_PING;
        else if (pick < 85)
          it.command = (cfg_role == ROLE_MASTER) ? CMD_SEND_STATS : CMD_REQ_STATS;
        else
          it.command = 3'($urandom_range(0, 3));

        pick = $urandom_range(0, 99);
        if (pick < 40)      it.error_kind = ERR_TIMEOUT;
        else if (pick < 80) it.error_kind = ERR_OVERRUN;
        else if (pick < 90) it.error_kind = ERR_UNEXP_ROLE;
        else                it.error_kind = ERR_OTHER;

        send_item(it, 1'b0, res_item_t'('0));
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && link_reports_due.size() != 0; k++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (link_reports_due.size() != 0) begin
      $display("%0d expected results never arrived", link_reports_due.size());
      errors += link_reports_due.size();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiving side: random stalls on ready, each accepted result compared
  // with the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin : collector
    int unsigned stall;
    bit          rx_burst;
    res_item_t   got;
    res_item_t   want;
    res_if.ready = 1'b0;
    rx_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      got = '{res_if.send_valid, res_if.send_command, res_if.link_state_out,
              res_if.packet_error, res_if.stats_accepted};
      if (link_reports_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("cycle %0d: result with nothing expected (send %b cmd %0d state %0d)",
                   cycle_count, got.send_valid, got.send_command, got.link_state_out);
      end else begin
        want = link_reports_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display({"cycle %0d: expected send %b cmd %0d state %0d perr %0d acc %b, ",
                      "got send %b cmd %0d state %0d perr %0d acc %b"}, cycle_count,
                     want.send_valid, want.send_command, want.link_state_out,
                     want.packet_error, want.stats_accepted,
                     got.send_valid, got.send_command, got.link_state_out,
                     got.packet_error, got.stats_accepted);
        end
      end
    end
  end

  // Watchdog: far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
